// File: hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent is checked by a non-overlapping implication on the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/blpw_pkg.sv
`default_nettype none

package blpw_pkg;

    localparam int SCREEN_WIDTH    = 640;
    localparam int SCREEN_HEIGHT   = 480;
    localparam int STRIDE_BYTES_8  = 640;
    localparam int STRIDE_BYTES_24 = 1920;

    localparam int X_W      = 10;
    localparam int Y_W      = 9;
    localparam int COLOR_W  = 24;
    localparam int ADDR_W   = 20;
    localparam int BCNT_W   = 2;
    localparam int ERR_W    = 12;
    localparam int STRIDE_W = 14;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [BCNT_W-1:0] BYTES_8BPP  = BCNT_W'(1);
    localparam logic [BCNT_W-1:0] BYTES_24BPP = BCNT_W'(3);

    localparam logic [COLOR_W-1:0] RGB332_R_MASK = COLOR_W'('he0);
    localparam logic [COLOR_W-1:0] RGB332_G_MASK = COLOR_W'('h1c);
    localparam logic [COLOR_W-1:0] RGB332_B_MASK = COLOR_W'('h03);

    typedef enum logic {
        KIND_LOAD    = 1'b0,
        KIND_ADVANCE = 1'b1
    } t_kind;

    typedef enum logic {
        MODE_8BPP  = 1'b0,
        MODE_24BPP = 1'b1
    } t_pix_mode;

    typedef struct packed {
        t_kind                    kind;
        logic [X_W-1:0]           x0;
        logic [Y_W-1:0]           y0;
        logic [X_W-1:0]           x1;
        logic [Y_W-1:0]           y1;
        logic [X_W-1:0]           dist_x;
        logic signed [X_W-1:0]    neg_dist_y;
        logic                     dir_x_neg;
        logic                     dir_y_neg;
        logic signed [ERR_W-1:0]  err_init;
        logic [COLOR_W-1:0]       color;
    } t_entry;

    typedef struct packed {
        logic valid;
        logic full;
    } t_q_status;

endpackage

`default_nettype wire

// File: hdl/blpw_intf.sv
`default_nettype none

interface blpw_in_if import blpw_pkg::*;;
    logic               valid;
    logic               ready;
    logic               kind;
    logic [X_W-1:0]     start_x;
    logic [Y_W-1:0]     start_y;
    logic [X_W-1:0]     end_x;
    logic [Y_W-1:0]     end_y;
    logic [COLOR_W-1:0] line_color;

    modport source (output valid, kind, start_x, start_y, end_x, end_y, line_color,
                    input ready);
    modport sink   (input valid, kind, start_x, start_y, end_x, end_y, line_color,
                    output ready);
endinterface

interface blpw_out_if import blpw_pkg::*;;
    logic               valid;
    logic               ready;
    logic [ADDR_W-1:0]  write_address;
    logic [COLOR_W-1:0] write_data;
    logic [BCNT_W-1:0]  byte_count;
    logic               last_pixel;

    modport source (output valid, write_address, write_data, byte_count, last_pixel,
                    input ready);
    modport sink   (input valid, write_address, write_data, byte_count, last_pixel,
                    output ready);
endinterface

interface blpw_cfg_if;
    logic valid;
    logic ready;
    logic pixel_mode;

    modport source (output valid, pixel_mode, input ready);
    modport sink   (input valid, pixel_mode, output ready);
endinterface

`default_nettype wire

// File: hdl/blpw_front.sv
`default_nettype none

module blpw_front import blpw_pkg::*; (
    blpw_in_if.sink   i_pix,
    input  wire logic i_q_full,
    output logic      o_push,
    output t_entry    o_entry
);

    function automatic logic [X_W-1:0] clamp_x(input logic [X_W-1:0] v);
        if (int'(v) > SCREEN_WIDTH - 1) begin
            return X_W'(SCREEN_WIDTH - 1);
        end
        return v;
    endfunction

    function automatic logic [Y_W-1:0] clamp_y(input logic [Y_W-1:0] v);
        if (int'(v) > SCREEN_HEIGHT - 1) begin
            return Y_W'(SCREEN_HEIGHT - 1);
        end
        return v;
    endfunction

    logic [X_W-1:0]        w_x0;
    logic [X_W-1:0]        w_x1;
    logic [Y_W-1:0]        w_y0;
    logic [Y_W-1:0]        w_y1;
    logic [X_W-1:0]        w_dx;
    logic [Y_W-1:0]        w_dy;
    logic signed [X_W-1:0] w_neg_dy;

    assign i_pix.ready = !i_q_full;
    assign o_push      = i_pix.valid && !i_q_full;

    always_comb begin
        w_x0     = clamp_x(i_pix.start_x);
        w_y0     = clamp_y(i_pix.start_y);
        w_x1     = clamp_x(i_pix.end_x);
        w_y1     = clamp_y(i_pix.end_y);
        w_dx     = (w_x1 >= w_x0) ? (w_x1 - w_x0) : (w_x0 - w_x1);
        w_dy     = (w_y1 >= w_y0) ? (w_y1 - w_y0) : (w_y0 - w_y1);
        w_neg_dy = -$signed({1'b0, w_dy});

        o_entry.kind       = t_kind'(i_pix.kind);
        o_entry.x0         = w_x0;
        o_entry.y0         = w_y0;
        o_entry.x1         = w_x1;
        o_entry.y1         = w_y1;
        o_entry.dist_x     = w_dx;
        o_entry.neg_dist_y = w_neg_dy;
        o_entry.dir_x_neg  = !(w_x0 < w_x1);
        o_entry.dir_y_neg  = !(w_y0 < w_y1);
        o_entry.err_init   = $signed({{(ERR_W - X_W){1'b0}}, w_dx})
                           + $signed({{(ERR_W - X_W){w_neg_dy[X_W-1]}}, w_neg_dy});
        o_entry.color      = i_pix.line_color;
    end

endmodule

`default_nettype wire

// File: hdl/blpw_queue.sv
`default_nettype none

`include "assert_macros.svh"

module blpw_queue import blpw_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_entry i_entry,
    input  wire logic   i_pop,
    output t_entry      o_entry,
    output t_q_status   o_status
);

    t_entry            r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [QCNT_W-1:0] n_count;

    assign o_entry        = r_mem[r_rd_ptr];
    assign o_status.valid = (r_count != '0);
    assign o_status.full  = (r_count == QCNT_W'(QUEUE_DEPTH));

    always_comb begin
        n_count = r_count;
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    `ASSERT_ALWAYS(a_q_bound, i_clk, i_rst_n, r_count <= QCNT_W'(QUEUE_DEPTH), "queue overrun")
    `ASSERT_NEXT(a_q_grow, i_clk, i_rst_n, i_push && !i_pop, r_count == $past(r_count) + 1'b1, "queue count lost a push")
    `ASSERT_ALWAYS(a_q_pop_data, i_clk, i_rst_n, !i_pop || (r_count != '0), "pop from empty queue")

endmodule

`default_nettype wire

// File: hdl/blpw_back.sv
`default_nettype none

`include "assert_macros.svh"

module blpw_back import blpw_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    blpw_cfg_if.sink       i_cfg,
    input  wire t_entry    i_entry,
    input  wire t_q_status i_q_status,
    output logic           o_pop,
    blpw_out_if.source     o_wr
);

    function automatic logic [COLOR_W-1:0] to_rgb332(input logic [COLOR_W-1:0] c);
        return ((c >> 16) & RGB332_R_MASK) | ((c >> 11) & RGB332_G_MASK)
             | ((c >> 6) & RGB332_B_MASK);
    endfunction

    localparam int PROD_W = Y_W + STRIDE_W;
    localparam int SUM_W  = PROD_W + 1;

    t_pix_mode               r_mode;
    logic                    r_busy;
    logic [X_W-1:0]          r_cur_x;
    logic [Y_W-1:0]          r_cur_y;
    logic [X_W-1:0]          r_goal_x;
    logic [Y_W-1:0]          r_goal_y;
    logic [X_W-1:0]          r_dist_x;
    logic signed [X_W-1:0]   r_neg_dy;
    logic                    r_dir_x_neg;
    logic                    r_dir_y_neg;
    logic signed [ERR_W-1:0] r_err;
    logic [COLOR_W-1:0]      r_color;

    logic                    r_out_valid;
    logic [ADDR_W-1:0]       r_addr;
    logic [COLOR_W-1:0]      r_data;
    logic [BCNT_W-1:0]       r_bcnt;
    logic                    r_last;

    logic                    w_emit;
    logic                    w_last;
    logic                    w_step_x;
    logic                    w_step_y;
    logic signed [ERR_W:0]   w_twice;
    logic [STRIDE_W-1:0]     w_stride;
    logic [PROD_W-1:0]       w_row;
    logic [X_W+1:0]          w_col;
    logic [SUM_W-1:0]        w_sum;
    logic [X_W-1:0]          n_cur_x;
    logic [Y_W-1:0]          n_cur_y;
    logic signed [ERR_W-1:0] n_err;

    assign i_cfg.ready = 1'b1;

    assign o_pop  = i_q_status.valid && (!r_out_valid || o_wr.ready);
    assign w_emit = o_pop && (i_entry.kind == KIND_ADVANCE) && r_busy;
    assign w_last = (r_cur_x == r_goal_x) && (r_cur_y == r_goal_y);

    always_comb begin
        w_stride = (r_mode == MODE_24BPP) ? STRIDE_W'(STRIDE_BYTES_24)
                                          : STRIDE_W'(STRIDE_BYTES_8);
        w_row    = PROD_W'(r_cur_y) * PROD_W'(w_stride);
        if (r_mode == MODE_24BPP) begin
            w_col = ((X_W + 2)'(r_cur_x) << 1) + (X_W + 2)'(r_cur_x);
        end else begin
            w_col = (X_W + 2)'(r_cur_x);
        end
        w_sum = SUM_W'(w_row) + SUM_W'(w_col);

        // error step, both tests on the error before either update
        w_twice  = {r_err, 1'b0};
        w_step_x = w_twice >= $signed({{(ERR_W + 1 - X_W){r_neg_dy[X_W-1]}}, r_neg_dy});
        w_step_y = w_twice <= $signed({{(ERR_W + 1 - X_W){1'b0}}, r_dist_x});

        n_err   = r_err;
        n_cur_x = r_cur_x;
        n_cur_y = r_cur_y;
        if (w_step_x) begin
            n_err   = n_err + $signed({{(ERR_W - X_W){r_neg_dy[X_W-1]}}, r_neg_dy});
            n_cur_x = r_dir_x_neg ? (r_cur_x - 1'b1) : (r_cur_x + 1'b1);
        end
        if (w_step_y) begin
            n_err   = n_err + $signed({{(ERR_W - X_W){1'b0}}, r_dist_x});
            n_cur_y = r_dir_y_neg ? (r_cur_y - 1'b1) : (r_cur_y + 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_8BPP;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_mode <= t_pix_mode'(i_cfg.pixel_mode);
            end
            if (o_pop && (i_entry.kind == KIND_LOAD)) begin
                r_busy <= 1'b1;
            end else if (w_emit && w_last) begin
                r_busy <= 1'b0;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_wr.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && (i_entry.kind == KIND_LOAD)) begin
            r_cur_x     <= i_entry.x0;
            r_cur_y     <= i_entry.y0;
            r_goal_x    <= i_entry.x1;
            r_goal_y    <= i_entry.y1;
            r_dist_x    <= i_entry.dist_x;
            r_neg_dy    <= i_entry.neg_dist_y;
            r_dir_x_neg <= i_entry.dir_x_neg;
            r_dir_y_neg <= i_entry.dir_y_neg;
            r_err       <= i_entry.err_init;
            r_color     <= i_entry.color;
        end else if (w_emit && !w_last) begin
            r_cur_x <= n_cur_x;
            r_cur_y <= n_cur_y;
            r_err   <= n_err;
        end
        if (w_emit) begin
            r_addr <= w_sum[ADDR_W-1:0];
            r_data <= (r_mode == MODE_24BPP) ? r_color : to_rgb332(r_color);
            r_bcnt <= (r_mode == MODE_24BPP) ? BYTES_24BPP : BYTES_8BPP;
            r_last <= w_last;
        end
    end

    assign o_wr.valid         = r_out_valid;
    assign o_wr.write_address = r_addr;
    assign o_wr.write_data    = r_data;
    assign o_wr.byte_count    = r_bcnt;
    assign o_wr.last_pixel    = r_last;

    `ASSERT_NEXT(a_load_busy, i_clk, i_rst_n, o_pop && (i_entry.kind == KIND_LOAD), r_busy, "load did not start a walk")
    `ASSERT_NEXT(a_emit_out, i_clk, i_rst_n, w_emit, r_out_valid, "pixel word dropped")
    `ASSERT_ALWAYS(a_on_screen, i_clk, i_rst_n, !r_busy || ((int'(r_cur_x) < SCREEN_WIDTH) && (int'(r_cur_y) < SCREEN_HEIGHT)), "walk left the screen")

endmodule

`default_nettype wire

// File: hdl/bresenham_line_pixel_writer.sv
// Line pixel writer: walks a line between two screen points and issues one
// framebuffer write word per pixel.
// i_pix carries command words: a load word (kind 0) latches the endpoints,
// clamped to the screen, and the colour, replacing any line in progress; an
// advance word (kind 1) produces the write for the current pixel and steps.
// An advance with no line active is consumed and gives no output word.
// o_wr carries address, data, byte count and a last-pixel flag; the end point
// word has last_pixel set and the engine then goes idle.
// i_cfg writes pixel_mode (0: 8 bpp RGB332, 1: 24 bpp), always ready.
// Throughput: one command word per clock, sustained while o_wr.ready is high,
// with a write word per clock; walk step and address multiply are combinational.
// An output word is registered: its command passes through a 2-entry command
// queue and then the output register.
// Reset clears the queue, drops any active line and selects 8 bpp.
// When the receiver stalls the output word holds, the queue fills with two
// commands and i_pix.ready then drops until o_wr.ready returns.
`default_nettype none

module bresenham_line_pixel_writer import blpw_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    blpw_in_if.sink    i_pix,
    blpw_cfg_if.sink   i_cfg,
    blpw_out_if.source o_wr
);

    logic      w_push;
    logic      w_pop;
    t_entry    w_front_entry;
    t_entry    w_back_entry;
    t_q_status w_q_status;

    blpw_front u_front (
        .i_pix    (i_pix),
        .i_q_full (w_q_status.full),
        .o_push   (w_push),
        .o_entry  (w_front_entry)
    );

    blpw_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_entry  (w_front_entry),
        .i_pop    (w_pop),
        .o_entry  (w_back_entry),
        .o_status (w_q_status)
    );

    blpw_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (i_cfg),
        .i_entry    (w_back_entry),
        .i_q_status (w_q_status),
        .o_pop      (w_pop),
        .o_wr       (o_wr)
    );

endmodule

`default_nettype wire
